[rtl/box_filter_3x3_rgb_assert.svh]
// Assertion helpers for the box filter.
// Both expect signals named clock and reset in the including scope.
`ifndef BOX_FILTER_3X3_RGB_ASSERT_SVH
`define BOX_FILTER_3X3_RGB_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFRGB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFRGB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bfrgb_pkg.sv]
package bfrgb_pkg;

   localparam int PIX_W = 16;
   localparam int ROW_W = 10;
   localparam int CSR_W = 11;
   localparam int CS_W  = PIX_W + 2;   // sum of three pixels
   localparam int SUM_W = PIX_W + 4;   // sum of nine pixels

   localparam int MAX_SIDE_DEF   = 1024;
   localparam int FRAME_SIZE_RST = 32;
   localparam int QDEPTH         = 2;

   // floor(x / 3) == (x * RECIP3) >> RECIP3_SH, exact for x below 2**21
   localparam int RECIP3_SH = 21;
   localparam logic [SUM_W-1:0] RECIP3 = SUM_W'(((1 << RECIP3_SH) + 2) / 3);

   // channel 0 red, 1 green, 2 blue
   typedef logic [2:0][PIX_W-1:0] pix_type;
   // entry 0 holds the older row, entry 1 the newer row
   typedef pix_type [1:0] line_type;
   // window indexed [row][col], row 2 and col 2 are the newest
   typedef pix_type [2:0][2:0] win_type;

   typedef enum logic [2:0] {
      DIV1,
      DIV2,
      DIV3,
      DIV4,
      DIV6,
      DIV9
   } div_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
      logic             run_last;
      logic             frame_done;
   } meta_type;

   typedef struct packed {
      win_type    win;
      logic [2:0] row_mask;
      logic [2:0] col_mask;
      meta_type   meta;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [SUM_W-1:0] div3(input logic [SUM_W-1:0] x);
      logic [2*SUM_W-1:0] prod;
      prod = x * RECIP3;
      return SUM_W'(prod >> RECIP3_SH);
   endfunction

endpackage

[rtl/bfrgb_if.sv]
interface bfrgb_req_if;
   logic                        valid;
   logic                        ready;
   logic [bfrgb_pkg::PIX_W-1:0] red;
   logic [bfrgb_pkg::PIX_W-1:0] green;
   logic [bfrgb_pkg::PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bfrgb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bfrgb_pkg::PIX_W-1:0] out_red;
   logic [bfrgb_pkg::PIX_W-1:0] out_green;
   logic [bfrgb_pkg::PIX_W-1:0] out_blue;
   logic [bfrgb_pkg::ROW_W-1:0] out_row;
   logic [bfrgb_pkg::ROW_W-1:0] out_col;
   logic                        run_last;
   logic                        frame_done;

   modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                   run_last, frame_done, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                   run_last, frame_done, output ready);
endinterface

[rtl/bfrgb_ram.sv]
module bfrgb_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/bfrgb_front.sv]
module bfrgb_front #(
   parameter int MAX_SIDE = bfrgb_pkg::MAX_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bfrgb_pkg::CSR_W-1:0] csr_wdata,
   bfrgb_req_if.sink                   req,
   input  logic                        q_ready,
   output logic                        job_push,
   output bfrgb_pkg::job_type          job
);

   localparam int PW       = $clog2(MAX_SIDE);
   localparam int CMP_W    = (bfrgb_pkg::CSR_W > PW + 1) ? bfrgb_pkg::CSR_W : PW + 1;
   localparam int RST_SIDE = (bfrgb_pkg::FRAME_SIZE_RST > MAX_SIDE) ?
                             MAX_SIDE : bfrgb_pkg::FRAME_SIZE_RST;
   localparam int LINE_W   = $bits(bfrgb_pkg::line_type);

   logic [PW-1:0]       last_idx_ff, last_idx_in;
   logic [PW-1:0]       col_ff, col_in, row_ff, row_in;
   logic [CMP_W-1:0]    wd_ext;
   logic                last_col, last_row, accept, push, leave;
   logic [3:0]          pend_init, pend_low, pend_rest;
   logic [1:0]          sel;
   logic                row_cur, col_cur, fwd_in;
   logic [LINE_W-1:0]   ram_rd;
   bfrgb_pkg::line_type line_cur, wr_line;
   bfrgb_pkg::pix_type  col2 [3];

   logic                f1_valid_ff;
   logic [3:0]          f1_pend_ff;
   bfrgb_pkg::pix_type  f1_pix_ff;
   logic [PW-1:0]       f1_row_ff, f1_col_ff;
   logic                f1_r1_ff, f1_r2_ff, f1_c1_ff, f1_c2_ff, f1_corner_ff;
   logic                fwd_ff;
   bfrgb_pkg::line_type fwd_data_ff;
   bfrgb_pkg::pix_type  w_ff [3][2];

   // clamp the written side and keep side - 1
   always_comb begin
      wd_ext = CMP_W'(csr_wdata);
      if (wd_ext == '0) begin
         last_idx_in = '0;
      end else if (wd_ext > CMP_W'(MAX_SIDE)) begin
         last_idx_in = PW'(MAX_SIDE - 1);
      end else begin
         last_idx_in = PW'(wd_ext - CMP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= PW'(RST_SIDE - 1);
      end else if (csr_we) begin
         last_idx_ff <= last_idx_in;
      end
   end

   assign last_col  = (col_ff == last_idx_ff);
   assign last_row  = (row_ff == last_idx_ff);
   assign req.ready = !f1_valid_ff || leave;
   assign accept    = req.valid && req.ready;

   // advance the raster position, restart on a side write
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + PW'(1);
         end else begin
            col_in = col_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // results owed: (r-1,c-1), (r-1,c), (r,c-1), (r,c) in raster order
   assign pend_init = {last_row && last_col, last_row && (col_ff != '0),
                       (row_ff != '0) && last_col, (row_ff != '0) && (col_ff != '0)};

   // line stores: read at accept, rewrite when the request leaves
   bfrgb_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_SIDE)
   ) u_line (
      .clock   (clock),
      .wr_en   (leave),
      .wr_addr (f1_col_ff),
      .wr_data (wr_line),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   // bypass the store when the previous request wrote this column at our read
   assign line_cur = fwd_ff ? fwd_data_ff : bfrgb_pkg::line_type'(ram_rd);
   assign wr_line  = {f1_pix_ff, line_cur[1]};
   assign fwd_in   = leave && (f1_col_ff == col_ff);

   always_comb begin
      col2[0] = line_cur[0];
      col2[1] = line_cur[1];
      col2[2] = f1_pix_ff;
   end

   // pick the next owed result
   always_comb begin
      priority if (f1_pend_ff[0]) begin
         sel = 2'd0;
      end else if (f1_pend_ff[1]) begin
         sel = 2'd1;
      end else if (f1_pend_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
   end

   assign pend_low  = f1_pend_ff & (~f1_pend_ff + 4'd1);
   assign pend_rest = f1_pend_ff & ~pend_low;
   assign push      = f1_valid_ff && (f1_pend_ff != '0) && q_ready;
   assign leave     = f1_valid_ff && ((f1_pend_ff == '0) || (push && (pend_rest == '0)));
   assign job_push  = push;
   assign row_cur   = sel[1];
   assign col_cur   = sel[0];

   // build the job for the selected window
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         job.win[k][0] = w_ff[k][0];
         job.win[k][1] = w_ff[k][1];
         job.win[k][2] = col2[k];
      end
      job.row_mask        = row_cur ? {1'b1, f1_r1_ff, 1'b0} : {2'b11, f1_r2_ff};
      job.col_mask        = col_cur ? {1'b1, f1_c1_ff, 1'b0} : {2'b11, f1_c2_ff};
      job.meta.row        = bfrgb_pkg::ROW_W'(row_cur ? f1_row_ff : f1_row_ff - PW'(1));
      job.meta.col        = bfrgb_pkg::ROW_W'(col_cur ? f1_col_ff : f1_col_ff - PW'(1));
      job.meta.run_last   = (pend_rest == '0);
      job.meta.frame_done = (pend_rest == '0) && f1_corner_ff;
   end

   // hold the request while its results go out
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f1_pend_ff  <= '0;
      end else if (accept) begin
         f1_valid_ff <= 1'b1;
         f1_pend_ff  <= pend_init;
      end else begin
         if (leave) begin
            f1_valid_ff <= 1'b0;
         end
         if (push) begin
            f1_pend_ff <= pend_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pix_ff    <= {req.blue, req.green, req.red};
         f1_row_ff    <= row_ff;
         f1_col_ff    <= col_ff;
         f1_r1_ff     <= (row_ff != '0);
         f1_r2_ff     <= (row_ff > PW'(1));
         f1_c1_ff     <= (col_ff != '0);
         f1_c2_ff     <= (col_ff > PW'(1));
         f1_corner_ff <= last_row && last_col;
         fwd_ff       <= fwd_in;
         fwd_data_ff  <= wr_line;
      end
   end

   // shift the window columns when the request leaves
   always_ff @(posedge clock) begin
      if (leave) begin
         for (int k = 0; k < 3; k++) begin
            w_ff[k][0] <= w_ff[k][1];
            w_ff[k][1] <= col2[k];
         end
      end
   end

endmodule

[rtl/bfrgb_queue.sv]
module bfrgb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bfrgb_pkg::job_type    push_data,
   input  logic                  pop,
   output bfrgb_pkg::job_type    pop_data,
   output bfrgb_pkg::q_stat_type stat
);

   localparam int PTR_W = $clog2(bfrgb_pkg::QDEPTH);
   localparam int CNT_W = $clog2(bfrgb_pkg::QDEPTH + 1);

   bfrgb_pkg::job_type mem_ff [bfrgb_pkg::QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign stat.full  = (cnt_ff == CNT_W'(bfrgb_pkg::QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(bfrgb_pkg::QDEPTH - 1)) ?
                         '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(bfrgb_pkg::QDEPTH - 1)) ?
                         '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/bfrgb_back.sv]
module bfrgb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bfrgb_pkg::q_stat_type q_stat,
   input  bfrgb_pkg::job_type    job,
   output logic                  pop,
   bfrgb_rsp_if.source           rsp
);

   localparam int CS_W  = bfrgb_pkg::CS_W;
   localparam int SUM_W = bfrgb_pkg::SUM_W;
   localparam int PIX_W = bfrgb_pkg::PIX_W;

   logic                           adv;
   logic [2:0][2:0][CS_W-1:0]      colsum;
   logic [2:0][SUM_W-1:0]          tot, pre, q3, q9;
   logic [3:0]                     cnt;
   bfrgb_pkg::div_type             div_in;

   logic                           b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [2:0][2:0][CS_W-1:0]      b1_sum_ff;
   logic [1:0]                     b1_rn_ff, b1_cn_ff;
   logic [2:0]                     b1_cmask_ff;
   bfrgb_pkg::meta_type            b1_meta_ff, b2_meta_ff, b3_meta_ff, b4_meta_ff;
   logic [2:0][SUM_W-1:0]          b2_tot_ff, b3_val_ff;
   bfrgb_pkg::div_type             b2_div_ff, b3_div_ff;
   logic [2:0][PIX_W-1:0]          b4_out_ff;

   // the whole pipe moves when the output slot is free or taken
   assign adv = !b4_valid_ff || rsp.ready;
   assign pop = adv && !q_stat.empty;

   // column sums over the rows in the window
   always_comb begin
      for (int m = 0; m < 3; m++) begin
         for (int ch = 0; ch < 3; ch++) begin
            colsum[m][ch] = '0;
            for (int k = 0; k < 3; k++) begin
               if (job.row_mask[k]) begin
                  colsum[m][ch] = colsum[m][ch] + CS_W'(job.win[k][m][ch]);
               end
            end
         end
      end
   end

   // total over the columns in the window
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         tot[ch] = '0;
         for (int m = 0; m < 3; m++) begin
            if (b1_cmask_ff[m]) begin
               tot[ch] = tot[ch] + SUM_W'(b1_sum_ff[m][ch]);
            end
         end
      end
   end

   // pixel count of the window
   assign cnt = {2'b00, b1_rn_ff} * {2'b00, b1_cn_ff};

   always_comb begin
      unique case (cnt)
         4'd2:    div_in = bfrgb_pkg::DIV2;
         4'd3:    div_in = bfrgb_pkg::DIV3;
         4'd4:    div_in = bfrgb_pkg::DIV4;
         4'd6:    div_in = bfrgb_pkg::DIV6;
         4'd9:    div_in = bfrgb_pkg::DIV9;
         default: div_in = bfrgb_pkg::DIV1;
      endcase
   end

   // drop the power-of-two factor, then divide by three, and by three again for nine
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         unique case (b2_div_ff)
            bfrgb_pkg::DIV2, bfrgb_pkg::DIV6: pre[ch] = b2_tot_ff[ch] >> 1;
            bfrgb_pkg::DIV4:                  pre[ch] = b2_tot_ff[ch] >> 2;
            default:                          pre[ch] = b2_tot_ff[ch];
         endcase
         q3[ch] = ((b2_div_ff == bfrgb_pkg::DIV3) || (b2_div_ff == bfrgb_pkg::DIV6) ||
                   (b2_div_ff == bfrgb_pkg::DIV9)) ? bfrgb_pkg::div3(pre[ch]) : pre[ch];
         q9[ch] = (b3_div_ff == bfrgb_pkg::DIV9) ? bfrgb_pkg::div3(b3_val_ff[ch]) :
                  b3_val_ff[ch];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= !q_stat.empty;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         b1_sum_ff   <= colsum;
         b1_rn_ff    <= 2'($countones(job.row_mask));
         b1_cn_ff    <= 2'($countones(job.col_mask));
         b1_cmask_ff <= job.col_mask;
         b1_meta_ff  <= job.meta;
         b2_tot_ff   <= tot;
         b2_div_ff   <= div_in;
         b2_meta_ff  <= b1_meta_ff;
         b3_val_ff   <= q3;
         b3_div_ff   <= b2_div_ff;
         b3_meta_ff  <= b2_meta_ff;
         for (int ch = 0; ch < 3; ch++) begin
            b4_out_ff[ch] <= PIX_W'(q9[ch]);
         end
         b4_meta_ff  <= b3_meta_ff;
      end
   end

   assign rsp.valid      = b4_valid_ff;
   assign rsp.out_red    = b4_out_ff[0];
   assign rsp.out_green  = b4_out_ff[1];
   assign rsp.out_blue   = b4_out_ff[2];
   assign rsp.out_row    = b4_meta_ff.row;
   assign rsp.out_col    = b4_meta_ff.col;
   assign rsp.run_last   = b4_meta_ff.run_last;
   assign rsp.frame_done = b4_meta_ff.frame_done;

endmodule

[rtl/box_filter_3x3_rgb.sv]
// 3x3 box filter over a square RGB frame streamed in raster order. Each
// request carries one pixel; each response is the truncated per-channel mean
// of one output pixel's clipped 3x3 window, tagged with its row and column.
// One request is taken per clock unless the last one's results are still
// going out. A request causes no response on the first row and column, one
// elsewhere, two on the last row or the last column and up to four at the
// bottom-right pixel; the front stage emits one result per clock into a
// two-entry queue while it has room, so extra results stall the input.
// Results are built in the request register, then pass the job queue and a
// four-stage sum and divide pipe. The user writes the side register only
// while the block is idle; the block does not enforce it. A write restarts the
// frame at row 0, column 0; the line stores need no clearing pass after reset.
`include "box_filter_3x3_rgb_assert.svh"

module box_filter_3x3_rgb #(
   parameter int MAX_SIDE = bfrgb_pkg::MAX_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bfrgb_pkg::CSR_W-1:0] csr_wdata,
   bfrgb_req_if.sink                   req_chan,
   bfrgb_rsp_if.source                 rsp_chan
);

   logic                  job_push, job_pop;
   bfrgb_pkg::job_type    job_in, job_out;
   bfrgb_pkg::q_stat_type q_stat;

   // classify requests into result jobs
   bfrgb_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .q_ready   (!q_stat.full),
      .job_push  (job_push),
      .job       (job_in)
   );

   bfrgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .stat      (q_stat)
   );

   // sum and divide
   bfrgb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .job    (job_out),
      .pop    (job_pop),
      .rsp    (rsp_chan)
   );

   `BFRGB_ASSERT_SAME(a_no_push_full, job_push, !q_stat.full, "job pushed into a full queue")
   `BFRGB_ASSERT_NEXT(a_push_fills, job_push && q_stat.empty, !q_stat.empty, "pushed job lost")
   `BFRGB_ASSERT_SAME(a_done_is_last, rsp_chan.valid && rsp_chan.frame_done, rsp_chan.run_last, "frame end not last of its request")
   `BFRGB_ASSERT_SAME(a_done_corner, rsp_chan.valid && rsp_chan.frame_done, rsp_chan.out_row == rsp_chan.out_col, "frame end off the corner")

endmodule

[test/tb_top.sv]
module tb_top;

   localparam int SIDE_CAP    = 1024;
   localparam int SETTLE      = 12;
   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic [bfrgb_pkg::PIX_W-1:0] red;
      logic [bfrgb_pkg::PIX_W-1:0] green;
      logic [bfrgb_pkg::PIX_W-1:0] blue;
      logic [bfrgb_pkg::ROW_W-1:0] row;
      logic [bfrgb_pkg::ROW_W-1:0] col;
      logic                        run_last;
      logic                        frame_done;
   } smooth_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [bfrgb_pkg::CSR_W-1:0] csr_wdata = '0;

   bfrgb_req_if req_chan ();
   bfrgb_rsp_if rsp_chan ();

   box_filter_3x3_rgb uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // filter model state
   logic [47:0]                 older_line [SIDE_CAP];
   logic [47:0]                 newer_line [SIDE_CAP];
   logic [47:0]                 win_cols [6];
   int                          pos_col;
   int                          pos_row;
   logic [bfrgb_pkg::CSR_W-1:0] side_reg;

   smooth_type smooth_q[$];
   int      fail_count = 0;
   int      request_count = 0;
   int      result_count = 0;
   int      frame_count = 0;
   bit      idle_on = 1'b0;
   bit      long_hold_req = 1'b0;
   int      hold_left = 0;
   int      rsp_burst = 0;
   int      quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_frame();
      pos_col = 0;
      pos_row = 0;
      for (int k = 0; k < 6; k++) win_cols[k] = '0;
   endfunction

   // compute the smoothed pixels released by one request, then advance
   function automatic void smooth_pixel(input logic [15:0] r, g, b);
      int s, rr, cc, n, rlo, rhi, clo, chi, k, m;
      bit lr, lc;
      logic [47:0] win [3][3];
      logic [47:0] px;
      logic [31:0] sr, sg, sb, cnt;
      smooth_type batch[$];
      smooth_type e;
      s = side_reg;
      if (s == 0) s = 1;
      if (s > SIDE_CAP) s = SIDE_CAP;
      if (pos_row >= s || pos_col >= s) restart_frame();
      rr = pos_row;
      cc = pos_col;
      lr = (rr == s - 1);
      lc = (cc == s - 1);
      px = {b, g, r};
      for (k = 0; k < 3; k++) begin
         win[k][0] = win_cols[k*2];
         win[k][1] = win_cols[k*2+1];
      end
      win[0][2] = older_line[cc];
      win[1][2] = newer_line[cc];
      win[2][2] = px;
      for (int i = rr - 1; i <= rr; i++) begin
         if (i < 0 || (i == rr && !lr)) continue;
         for (int j = cc - 1; j <= cc; j++) begin
            if (j < 0 || (j == cc && !lc)) continue;
            rlo = (i > 0) ? i - 1 : 0;
            rhi = (i + 1 < s) ? i + 1 : s - 1;
            clo = (j > 0) ? j - 1 : 0;
            chi = (j + 1 < s) ? j + 1 : s - 1;
            sr = 0; sg = 0; sb = 0; cnt = 0;
            for (int y = rlo; y <= rhi; y++) begin
               for (int x = clo; x <= chi; x++) begin
                  k = y - rr + 2;
                  m = x - cc + 2;
                  if (k < 0 || k > 2 || m < 0 || m > 2) continue;
                  sr += win[k][m][15:0];
                  sg += win[k][m][31:16];
                  sb += win[k][m][47:32];
                  cnt++;
               end
            end
            if (cnt == 0) cnt = 1;
            e.red = 16'(sr / cnt);
            e.green = 16'(sg / cnt);
            e.blue = 16'(sb / cnt);
            e.row = bfrgb_pkg::ROW_W'(i);
            e.col = bfrgb_pkg::ROW_W'(j);
            e.run_last = 1'b0;
            e.frame_done = 1'b0;
            batch.push_back(e);
         end
      end
      n = batch.size();
      if (n > 0) begin
         batch[n-1].run_last = 1'b1;
         if (lr && lc) begin
            batch[n-1].frame_done = 1'b1;
            frame_count++;
         end
      end
      foreach (batch[q]) smooth_q.push_back(batch[q]);
      older_line[cc] = newer_line[cc];
      newer_line[cc] = px;
      for (k = 0; k < 3; k++) begin
         win_cols[k*2] = win[k][1];
         win_cols[k*2+1] = win[k][2];
      end
      cc++;
      if (cc >= s) begin
         cc = 0;
         rr++;
         if (rr >= s) begin
            restart_frame();
            rr = 0;
         end
      end
      pos_col = cc;
      pos_row = rr;
   endfunction

   // offer one request and hold it until taken
   task automatic send_pixel(input logic [15:0] r, g, b);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.red <= r;
      req_chan.green <= g;
      req_chan.blue <= b;
      do @(posedge clock); while (!req_chan.ready);
      smooth_pixel(r, g, b);
      request_count++;
   endtask

   function automatic logic [15:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_pixel(rand_chan(), rand_chan(), rand_chan());
   endtask

   // drop valid, wait out every response and the pipe tail
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (smooth_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_side(input logic [bfrgb_pkg::CSR_W-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      side_reg = v;
      restart_frame();
   endtask

   task automatic test_tiny_frames();
      write_side(11'd1);
      send_pixel(16'h0000, 16'hFFFF, 16'h1234);
      send_pixel(16'hFFFF, 16'h0000, 16'hA5A5);
      write_side(11'd2);
      send_random(8);
      write_side(11'd0);
      send_random(2);
   endtask

   task automatic test_extreme_values();
      write_side(11'd3);
      repeat (9) send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (9) send_pixel(16'h0000, 16'h0000, 16'h0000);
      write_side(11'd4);
      for (int i = 0; i < 16; i++) begin
         if (i[0]) send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
         else send_pixel(16'h0000, 16'hFFFF, 16'h0000);
      end
   endtask

   task automatic test_restart_mid_frame();
      write_side(11'd5);
      send_random(13);
      write_side(11'd5);
      send_random(25);
   endtask

   task automatic test_side_clamp();
      write_side(11'd2047);
      send_random(5);
      write_side(11'd1024);
      send_random(5);
   endtask

   task automatic test_backpressure_fill();
      write_side(11'd6);
      long_hold_req = 1'b1;
      send_random(36);
      drain();
      send_random(30);
   endtask

   task automatic test_random_frames(input int target);
      int s, n, done;
      done = 0;
      while (done < target) begin
         if ($urandom_range(0, 9) == 0) s = $urandom_range(11, 16);
         else s = $urandom_range(1, 10);
         write_side(11'(s));
         n = s * s;
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
         if (n > target - done) n = target - done;
         send_random(n);
         done += n;
      end
   endtask

   task automatic test_no_idle_tail();
      idle_on = 1'b0;
      write_side(11'd7);
      send_random(49);
   endtask

   // response ready: random bursts, plus a long hold on request
   always @(posedge clock) begin
      if (long_hold_req) begin
         hold_left = 250;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && rsp_burst > 0) begin
         rsp_burst--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_burst = $urandom_range(0, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      smooth_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.out_red, rsp_chan.out_green, rsp_chan.out_blue, rsp_chan.out_row,
                rsp_chan.out_col, rsp_chan.run_last, rsp_chan.frame_done};
         result_count++;
         if (smooth_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response r=%h g=%h b=%h row=%0d col=%0d",
                     $time, got.red, got.green, got.blue, got.row, got.col);
         end else begin
            want = smooth_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.row !== want.row || got.col !== want.col ||
                got.run_last !== want.run_last || got.frame_done !== want.frame_done) begin
               fail_count++;
               $display("%0t: expected r=%h g=%h b=%h row=%0d col=%0d last=%b done=%b",
                        $time, want.red, want.green, want.blue, want.row, want.col,
                        want.run_last, want.frame_done);
               $display("%0t: actual   r=%h g=%h b=%h row=%0d col=%0d last=%b done=%b",
                        $time, got.red, got.green, got.blue, got.row, got.col,
                        got.run_last, got.frame_done);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress, %0d predictions pending", $time, smooth_q.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      side_reg = 11'(bfrgb_pkg::FRAME_SIZE_RST);
      restart_frame();
      req_chan.valid <= 1'b0;
      req_chan.red <= '0;
      req_chan.green <= '0;
      req_chan.blue <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_tiny_frames();
      test_extreme_values();
      test_restart_mid_frame();
      test_side_clamp();
      test_backpressure_fill();
      test_random_frames(50);
      test_no_idle_tail();
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d full frames", request_count,
               result_count, frame_count);
      $display("sides 0 to 2047 with clamping, mid-frame restarts, a long response hold");
      if (fail_count == 0 && smooth_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/bfrgb_pkg.sv
rtl/bfrgb_if.sv
rtl/bfrgb_ram.sv
rtl/bfrgb_front.sv
rtl/bfrgb_queue.sv
rtl/bfrgb_back.sv
rtl/box_filter_3x3_rgb.sv
test/tb_top.sv
